// ===== rtl/rsi_pkg.sv =====
// Shared types and constants for the ray/sphere intersection block.
// Used by the front end, the square-root and divider cells and the top level.
// No dependencies.
package rsi_pkg;

  // Control that travels with each item down the pipeline.
  typedef struct packed {
    logic valid;
    logic miss;
  } ctl_t;

  // Configuration port geometry.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register index field of the byte address, and register codes.
  localparam int REG_IDX_W = CFG_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_MIN_DIST = '0;

  // Default minimum hit distance is one thousandth, kept as a divisor.
  localparam int MIN_DIST_DIV = 1000;

endpackage

// ===== rtl/rsi_front.sv =====
// Front end of the ray/sphere test: exact dot products and the discriminant.
// Six register stages; all of them advance together on the enable.
// Depends on rsi_pkg.
module rsi_front #(
  parameter int CB = 32,
  parameter int FB = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic signed [CB-1:0]   o_in [3],
  input  logic signed [CB-1:0]   d_in [3],
  input  logic signed [CB-1:0]   c_in [3],
  input  logic        [CB-2:0]   r_in,
  output rsi_pkg::ctl_t          ctl_out,
  output logic [4*CB+4+2*FB-1:0] x_out,
  output logic signed [2*CB+1:0] h_out,
  output logic [2*CB-1:0]        a_out
);

  localparam int AW  = 2 * CB;
  localparam int HW  = 2 * CB + 2;
  localparam int CW  = 2 * CB + 3;
  localparam int DW  = 4 * CB + 4;
  localparam int HM  = HW - 1;
  localparam int CM  = CW - 1;
  localparam int CH  = (HM + 3) / 4;
  localparam int CC  = (CM + 3) / 4;
  localparam int HPW = 4 * CH;
  localparam int CPW = 4 * CC;

  logic [6:1] v;

  logic signed [CB:0]     p1 [3];
  logic signed [CB-1:0]   d1 [3];
  logic        [CB-2:0]   r1;

  logic signed [2*CB-1:0] dd2 [3];
  logic signed [2*CB:0]   dp2 [3];
  logic signed [2*CB+1:0] pp2 [3];
  logic        [2*CB-3:0] rr2;

  logic        [AW-1:0]   a3;
  logic signed [HW-1:0]   h3;
  logic signed [CW-1:0]   c3;

  logic [HM-1:0]  hmag;
  logic [CM-1:0]  cmag;
  logic [HPW-1:0] hpad;
  logic [CPW-1:0] cpad;

  logic [HM+CH-1:0]     hpp4 [4];
  logic [AW+CC-1:0]     acp4 [4];
  logic [AW-1:0]        a4;
  logic signed [HW-1:0] h4;
  logic                 cneg4;

  logic [DW-1:0]        hh_sum;
  logic [DW-1:0]        ac_sum;
  logic [DW-1:0]        hh5;
  logic [DW-1:0]        ac5;
  logic [AW-1:0]        a5;
  logic signed [HW-1:0] h5;
  logic                 cneg5;

  logic signed [DW-1:0] disc6;
  logic [AW-1:0]        a6;
  logic signed [HW-1:0] h6;

  // Valid bits of all six stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[5:1], in_valid};
    end
  end

  // Magnitudes of h and c, split into four slices for the wide products.
  always_comb begin
    hmag = h3[HW-1] ? HM'(-h3) : HM'(h3);
    cmag = c3[CW-1] ? CM'(-c3) : CM'(c3);
    hpad = HPW'(hmag);
    cpad = CPW'(cmag);
  end

  // Recombine the partial products of h*h and a*|c|.
  always_comb begin
    hh_sum = '0;
    ac_sum = '0;
    for (int k = 0; k < 4; k++) begin
      hh_sum = hh_sum + (DW'(hpp4[k]) << (k * CH));
      ac_sum = ac_sum + (DW'(acp4[k]) << (k * CC));
    end
  end

  // Datapath stages.
  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: offset of the origin from the center.
      for (int k = 0; k < 3; k++) begin
        p1[k] <= (CB+1)'(o_in[k]) - (CB+1)'(c_in[k]);
        d1[k] <= d_in[k];
      end
      r1 <= r_in;
      // Stage 2: the ten products of the dot products.
      for (int k = 0; k < 3; k++) begin
        dd2[k] <= d1[k] * d1[k];
        dp2[k] <= d1[k] * p1[k];
        pp2[k] <= p1[k] * p1[k];
      end
      rr2 <= r1 * r1;
      // Stage 3: a, h and c.
      a3 <= AW'(dd2[0]) + AW'(dd2[1]) + AW'(dd2[2]);
      h3 <= HW'(dp2[0]) + HW'(dp2[1]) + HW'(dp2[2]);
      c3 <= CW'(pp2[0]) + CW'(pp2[1]) + CW'(pp2[2]) - $signed({1'b0, rr2});
      // Stage 4: partial products, one slice of the second operand each.
      for (int k = 0; k < 4; k++) begin
        hpp4[k] <= hmag * hpad[k*CH +: CH];
        acp4[k] <= a3 * cpad[k*CC +: CC];
      end
      a4    <= a3;
      h4    <= h3;
      cneg4 <= c3[CW-1];
      // Stage 5: full products.
      hh5   <= hh_sum;
      ac5   <= ac_sum;
      a5    <= a4;
      h5    <= h4;
      cneg5 <= cneg4;
      // Stage 6: quarter discriminant h*h - a*c.
      disc6 <= cneg5 ? $signed(hh5 + ac5) : $signed(hh5 - ac5);
      a6    <= a5;
      h6    <= h5;
    end
  end

  // A zero direction gives a zero discriminant, so one test covers both misses.
  assign ctl_out.valid = v[6];
  assign ctl_out.miss  = disc6[DW-1] || (disc6 == '0);
  assign x_out         = {1'b0, disc6[DW-2:0], {(2*FB){1'b0}}};
  assign h_out         = h6;
  assign a_out         = a6;

endmodule

// ===== rtl/rsi_sqrt_cell.sv =====
// One cell of the square-root chain: resolves one root bit per cell.
// Takes two radicand bits, does one trial subtract and hands on to the next cell.
// Depends on rsi_pkg.
module rsi_sqrt_cell #(
  parameter int XW     = 164,
  parameter int SW     = 82,
  parameter int SIDE_W = 130
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  rsi_pkg::ctl_t       ctl_in,
  input  logic [XW-1:0]       x_in,
  input  logic [SW-1:0]       root_in,
  input  logic [SW+1:0]       rem_in,
  input  logic [SIDE_W-1:0]   side_in,
  output rsi_pkg::ctl_t       ctl_out,
  output logic [XW-1:0]       x_out,
  output logic [SW-1:0]       root_out,
  output logic [SW+1:0]       rem_out,
  output logic [SIDE_W-1:0]   side_out
);

  logic          valid_q;
  logic          miss_q;
  logic [SW+1:0] rem_sh;
  logic [SW+1:0] trial;
  logic          take;

  // Bring down the next two radicand bits and try the subtract.
  always_comb begin
    rem_sh = {rem_in[SW-1:0], x_in[XW-1:XW-2]};
    trial  = {root_in, 2'b01};
    take   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      miss_q   <= ctl_in.miss;
      x_out    <= x_in << 2;
      root_out <= {root_in[SW-2:0], take};
      rem_out  <= take ? rem_sh - trial : rem_sh;
      side_out <= side_in;
    end
  end

  assign ctl_out.valid = valid_q;
  assign ctl_out.miss  = miss_q;

endmodule

// ===== rtl/rsi_div_cell.sv =====
// One cell of the restoring divider chain: resolves one quotient bit per cell.
// The partial remainder is compared with the shifted divisor and moves one bit up.
// Depends on rsi_pkg.
module rsi_div_cell #(
  parameter int RW     = 94,
  parameter int QW     = 31,
  parameter int AW     = 64,
  parameter int SH     = 30,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  rsi_pkg::ctl_t     ctl_in,
  input  logic [RW-1:0]     rem_in,
  input  logic [QW-1:0]     q_in,
  input  logic [AW-1:0]     a_in,
  input  logic [SIDE_W-1:0] side_in,
  output rsi_pkg::ctl_t     ctl_out,
  output logic [RW-1:0]     rem_out,
  output logic [QW-1:0]     q_out,
  output logic [AW-1:0]     a_out,
  output logic [SIDE_W-1:0] side_out
);

  logic          valid_q;
  logic          miss_q;
  logic [RW-1:0] dsh;
  logic [RW-1:0] rem_left;
  logic          take;

  // Trial subtract of the divisor at the top quotient weight.
  always_comb begin
    dsh      = RW'(a_in) << SH;
    take     = rem_in >= dsh;
    rem_left = take ? rem_in - dsh : rem_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      miss_q   <= ctl_in.miss;
      rem_out  <= rem_left << 1;
      q_out    <= {q_in[QW-2:0], take};
      a_out    <= a_in;
      side_out <= side_in;
    end
  end

  assign ctl_out.valid = valid_q;
  assign ctl_out.miss  = miss_q;

endmodule

// ===== rtl/ray_sphere_intersect.sv =====
// Ray/sphere intersection: one item per cycle, one result per item.
// The pipeline holds six front stages, one square-root cell per root bit, two stages
// for the numerator, one divider cell per result bit and the output register.
// Throughput is one transfer per cycle; only a full skid register stops intake.
// Synchronous reset empties the pipeline and sets min_distance to about 0.001.
module ray_sphere_intersect #(
  parameter int FRAC_BITS  = 16,
  parameter int COORD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rsi_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [rsi_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [rsi_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_BITS-1:0]        origin_x,
  input  logic signed [COORD_BITS-1:0]        origin_y,
  input  logic signed [COORD_BITS-1:0]        origin_z,
  input  logic signed [COORD_BITS-1:0]        dir_x,
  input  logic signed [COORD_BITS-1:0]        dir_y,
  input  logic signed [COORD_BITS-1:0]        dir_z,
  input  logic signed [COORD_BITS-1:0]        center_x,
  input  logic signed [COORD_BITS-1:0]        center_y,
  input  logic signed [COORD_BITS-1:0]        center_z,
  input  logic        [COORD_BITS-2:0]        sphere_radius,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                hit,
  output logic        [COORD_BITS-2:0]        hit_param
);

  localparam int CB   = COORD_BITS;
  localparam int FB   = FRAC_BITS;
  localparam int AW   = 2 * CB;
  localparam int HW   = 2 * CB + 2;
  localparam int XW   = 4 * CB + 4 + 2 * FB;
  localparam int SW   = XW / 2;
  localparam int NW   = 2 * CB + FB + 4;
  localparam int RW   = AW + CB - 1;
  localparam int QW   = CB - 1;
  localparam int CMPW = NW + AW + CB;
  localparam logic [FB-1:0] MIN_DIST_RESET =
    FB'(((64'd1 << FB) + rsi_pkg::MIN_DIST_DIV / 2) / rsi_pkg::MIN_DIST_DIV);

  logic          en;
  logic [FB-1:0] min_distance;

  logic signed [CB-1:0] o_vec [3];
  logic signed [CB-1:0] d_vec [3];
  logic signed [CB-1:0] c_vec [3];

  rsi_pkg::ctl_t          sq_ctl  [SW+1];
  logic [XW-1:0]          sq_x    [SW+1];
  logic [SW-1:0]          sq_root [SW+1];
  logic [SW+1:0]          sq_rem  [SW+1];
  logic [HW+AW-1:0]       sq_side [SW+1];
  logic signed [HW-1:0]   front_h;
  logic [AW-1:0]          front_a;

  logic                 n1_valid;
  logic                 n1_miss;
  logic signed [NW-1:0] n1_num;
  logic [AW-1:0]        n1_a;
  logic signed [NW-1:0] num_next;
  logic signed [HW-1:0] sq_h;
  logic [AW-1:0]        sq_a;

  rsi_pkg::ctl_t  n2_ctl;
  logic           n2_valid;
  logic           n2_miss;
  logic [CMPW-1:0] n2_num_ext;
  logic [RW-1:0]  n2_rem;
  logic [AW-1:0]  n2_a;
  logic           n2_sat;

  rsi_pkg::ctl_t dv_ctl  [QW+1];
  logic [RW-1:0] dv_rem  [QW+1];
  logic [QW-1:0] dv_q    [QW+1];
  logic [AW-1:0] dv_a    [QW+1];
  logic [0:0]    dv_side [QW+1];

  logic          new_valid;
  logic [QW-1:0] tq;
  logic          new_hit;
  logic [QW-1:0] new_param;
  logic          skid_full;
  logic          skid_hit;
  logic [QW-1:0] skid_param;

  // Configuration register; writes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_distance <= MIN_DIST_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[rsi_pkg::CFG_ADDR_W-1:2] == rsi_pkg::REG_MIN_DIST) begin
      min_distance <= pwdata[FB-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[rsi_pkg::CFG_ADDR_W-1:2] == rsi_pkg::REG_MIN_DIST) ?
                  rsi_pkg::CFG_DATA_W'(min_distance) : '0;

  // The whole pipeline moves unless the skid register holds a result.
  assign en       = !skid_full;
  assign in_ready = !skid_full;

  assign o_vec = '{origin_x, origin_y, origin_z};
  assign d_vec = '{dir_x, dir_y, dir_z};
  assign c_vec = '{center_x, center_y, center_z};

  rsi_front #(.CB(CB), .FB(FB)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .o_in     (o_vec),
    .d_in     (d_vec),
    .c_in     (c_vec),
    .r_in     (sphere_radius),
    .ctl_out  (sq_ctl[0]),
    .x_out    (sq_x[0]),
    .h_out    (front_h),
    .a_out    (front_a)
  );

  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;
  assign sq_side[0] = {front_h, front_a};

  // Square-root chain: one root bit per cell.
  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    rsi_sqrt_cell #(.XW(XW), .SW(SW), .SIDE_W(HW + AW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctl_in   (sq_ctl[i]),
      .x_in     (sq_x[i]),
      .root_in  (sq_root[i]),
      .rem_in   (sq_rem[i]),
      .side_in  (sq_side[i]),
      .ctl_out  (sq_ctl[i+1]),
      .x_out    (sq_x[i+1]),
      .root_out (sq_root[i+1]),
      .rem_out  (sq_rem[i+1]),
      .side_out (sq_side[i+1])
    );
  end

  // Numerator -(h << FRAC_BITS) - sqrt; a root at or behind the origin misses.
  always_comb begin
    sq_h     = sq_side[SW][HW+AW-1:AW];
    sq_a     = sq_side[SW][AW-1:0];
    num_next = -$signed({{2{sq_h[HW-1]}}, sq_h, {FB{1'b0}}}) -
               $signed({2'b00, sq_root[SW]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n1_valid <= 1'b0;
      n2_valid <= 1'b0;
    end else if (en) begin
      n1_valid <= sq_ctl[SW].valid;
      n2_valid <= n1_valid;
    end
  end

  // Saturation test: the quotient overflows when num >= a << (COORD_BITS-1).
  assign n2_num_ext = CMPW'($unsigned(n1_num));

  always_ff @(posedge clk) begin
    if (en) begin
      n1_num  <= num_next;
      n1_miss <= sq_ctl[SW].miss || num_next[NW-1] || (num_next == '0);
      n1_a    <= sq_a;
      n2_miss <= n1_miss;
      n2_sat  <= n2_num_ext >= (CMPW'(n1_a) << (CB - 1));
      n2_rem  <= n2_num_ext[RW-1:0];
      n2_a    <= n1_a;
    end
  end

  assign n2_ctl.valid = n2_valid;
  assign n2_ctl.miss  = n2_miss;
  assign dv_ctl[0]    = n2_ctl;
  assign dv_rem[0]    = n2_rem;
  assign dv_q[0]      = '0;
  assign dv_a[0]      = n2_a;
  assign dv_side[0]   = n2_sat;

  // Divider chain: one quotient bit per cell.
  for (genvar j = 0; j < QW; j++) begin : g_div
    rsi_div_cell #(.RW(RW), .QW(QW), .AW(AW), .SH(CB - 2), .SIDE_W(1)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctl_in   (dv_ctl[j]),
      .rem_in   (dv_rem[j]),
      .q_in     (dv_q[j]),
      .a_in     (dv_a[j]),
      .side_in  (dv_side[j]),
      .ctl_out  (dv_ctl[j+1]),
      .rem_out  (dv_rem[j+1]),
      .q_out    (dv_q[j+1]),
      .a_out    (dv_a[j+1]),
      .side_out (dv_side[j+1])
    );
  end

  // Saturate, then compare against the minimum distance.
  always_comb begin
    new_valid = en && dv_ctl[QW].valid;
    tq        = dv_side[QW][0] ? {QW{1'b1}} : dv_q[QW];
    new_hit   = !dv_ctl[QW].miss && (tq > QW'(min_distance));
    new_param = new_hit ? tq : '0;
  end

  // Output register with a one-entry skid behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (skid_full) begin
        skid_full <= 1'b0;
      end else begin
        out_valid <= new_valid;
      end
    end else if (!out_valid) begin
      out_valid <= new_valid;
    end else if (new_valid) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (skid_full) begin
        hit       <= skid_hit;
        hit_param <= skid_param;
      end else begin
        hit       <= new_hit;
        hit_param <= new_param;
      end
    end else if (!out_valid) begin
      hit       <= new_hit;
      hit_param <= new_param;
    end else if (new_valid) begin
      skid_hit   <= new_hit;
      skid_param <= new_param;
    end
  end

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_param == '0)
    else $error("miss result carries a nonzero hit parameter");

  a_hit_beyond_min: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> hit_param > QW'(min_distance))
    else $error("hit reported at or below the minimum distance");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid)
    else $error("skid register full while the output register is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_full && out_ready |=> !skid_full && out_valid)
    else $error("skid register did not drain after a transfer");
`endif

endmodule
